FILE: design/tpcm_pkg.sv
// tpcm_pkg: shared types and codes for the trusted proxy cidr match unit
// holds the request/response transaction structs, the rule entry and command codes
// no dependencies
package tpcm_pkg;

  localparam logic [1:0] CMD_CLEAR   = 2'd0;
  localparam logic [1:0] CMD_ADD     = 2'd1;
  localparam logic [1:0] CMD_RESOLVE = 2'd2;

  localparam logic [1:0] FAM_NONE = 2'd0;
  localparam logic [1:0] FAM_V4   = 2'd1;
  localparam logic [1:0] FAM_V6   = 2'd2;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_BAD  = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  localparam logic [7:0] V4_BITS = 8'd32;
  localparam logic [7:0] V6_BITS = 8'd128;

  typedef struct packed {
    logic [1:0]  command;
    logic [1:0]  family;
    logic [63:0] address_high;
    logic [63:0] address_low;
    logic [7:0]  prefix_length;
    logic        fwd_valid;
    logic        fwd_is_v6;
    logic [63:0] fwd_address_high;
    logic [63:0] fwd_address_low;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        trusted;
    logic        used_forwarded;
    logic [1:0]  out_family;
    logic [63:0] out_address_high;
    logic [63:0] out_address_low;
  } rsp_t;

  typedef struct packed {
    logic        is_v6;
    logic [7:0]  prefix;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
  } rule_t;

endpackage

FILE: design/tpcm_rule_match.sv
// tpcm_rule_match: compares one stored rule against the peer address
// builds the prefix mask from the rule's length and checks family and leading bits
// depends on tpcm_pkg
module tpcm_rule_match import tpcm_pkg::*; (
  input  rule_t       rule,
  input  logic        peer_v6,
  input  logic [63:0] peer_high,
  input  logic [63:0] peer_low,
  output logic        match
);

  logic [127:0] mask6;
  logic [31:0]  mask4;
  logic         hit6;
  logic         hit4;

  // top prefix bits set; stored prefix never exceeds the family width
  assign mask6 = ~({128{1'b1}} >> rule.prefix);
  assign mask4 = ~({32{1'b1}} >> rule.prefix);

  assign hit6 = ((({peer_high, peer_low} ^ {rule.addr_high, rule.addr_low}) & mask6) == '0);
  assign hit4 = (((peer_low[31:0] ^ rule.addr_low[31:0]) & mask4) == '0);

  assign match = (rule.is_v6 == peer_v6) && (peer_v6 ? hit6 : hit4);

endmodule

FILE: design/trusted_proxy_cidr_match_unit.sv
// trusted_proxy_cidr_match_unit: trusted proxy rule table with client address resolve
// rules live in a synchronous memory, a resolve scans it one entry per cycle
// depends on tpcm_pkg and tpcm_rule_match
//
//   channel | signals                  | direction | payload
//   req     | req_valid, req_ready     | in        | req_t: command, peer, forwarded address
//   rsp     | rsp_valid, rsp_ready     | out       | rsp_t: status, trusted, effective address
//
// clear, add and unknown commands pass from acceptance to the done state and then to a response transaction.
// a resolve with n stored rules scans at most n entries: the memory read port gives one
// entry per cycle and the compare acts on the read in the next cycle; a hit ends the scan early.
// rst empties the table (rule count to zero) and drops any pending transaction.
// req_ready is high whenever no command is in flight, even while a response waits;
// a finished command holds in its result register until the response register frees up.
module trusted_proxy_cidr_match_unit import tpcm_pkg::*; #(
  parameter int TABLE_DEPTH = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] rule_count;
  logic [CNT_W-1:0] issue_idx;
  logic             chk_valid;
  req_t             cur;
  rsp_t             res;
  rsp_t             start_res;

  rule_t            rule_mem [TABLE_DEPTH];
  rule_t            rd_data;
  rule_t            wr_entry;
  logic             mem_we;
  logic             rd_en;
  logic             match;

  logic             accept;
  logic             fam_ok;
  logic             prefix_ok;
  logic             table_full;
  logic             start_scan;
  logic             load_rsp;
  logic             peer_v6;
  logic [63:0]      fwd_high;
  logic [63:0]      fwd_low;
  logic             use_fwd;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;

  assign fam_ok     = (req.family == FAM_V4) || (req.family == FAM_V6);
  assign prefix_ok  = (req.family == FAM_V6) ? (req.prefix_length <= V6_BITS)
                                             : (req.prefix_length <= V4_BITS);
  assign table_full = (rule_count == CNT_W'(TABLE_DEPTH));

  assign mem_we = accept && (req.command == CMD_ADD) && fam_ok && prefix_ok && !table_full;

  assign start_scan = (req.command == CMD_RESOLVE) && fam_ok && (rule_count != '0);
  assign load_rsp   = (state == S_DONE) && (!rsp_valid || rsp_ready);

  always_comb begin
    wr_entry.is_v6     = (req.family == FAM_V6);
    wr_entry.prefix    = req.prefix_length;
    wr_entry.addr_high = (req.family == FAM_V6) ? req.address_high : 64'd0;
    wr_entry.addr_low  = (req.family == FAM_V6) ? req.address_low
                                                : {32'd0, req.address_low[31:0]};
  end

  // response fields known at acceptance
  always_comb begin
    start_res = '0;
    case (req.command)
      CMD_ADD: begin
        if (!fam_ok || !prefix_ok) begin
          start_res.status = STAT_BAD;
        end else if (table_full) begin
          start_res.status = STAT_FULL;
        end
      end
      CMD_RESOLVE: begin
        if (fam_ok) begin
          start_res.out_family       = req.family;
          start_res.out_address_high = (req.family == FAM_V6) ? req.address_high : 64'd0;
          start_res.out_address_low  = (req.family == FAM_V6) ? req.address_low
                                       : {32'd0, req.address_low[31:0]};
        end
      end
      default: begin
      end
    endcase
  end

  assign rd_en = (state == S_SCAN) && (issue_idx != rule_count);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      rule_mem[rule_count[IDX_W-1:0]] <= wr_entry;
    end
    if (rd_en) begin
      rd_data <= rule_mem[issue_idx[IDX_W-1:0]];
    end
  end

  assign peer_v6 = (cur.family == FAM_V6);

  tpcm_rule_match u_match (
    .rule      (rd_data),
    .peer_v6   (peer_v6),
    .peer_high (cur.address_high),
    .peer_low  (cur.address_low),
    .match     (match)
  );

  // forwarded address as it would be given, and whether it is specified
  assign fwd_high = cur.fwd_is_v6 ? cur.fwd_address_high : 64'd0;
  assign fwd_low  = cur.fwd_is_v6 ? cur.fwd_address_low : {32'd0, cur.fwd_address_low[31:0]};
  assign use_fwd  = cur.fwd_valid && ((fwd_high | fwd_low) != 64'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rule_count <= '0;
      issue_idx  <= '0;
      chk_valid  <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            cur       <= req;
            res       <= start_res;
            issue_idx <= '0;
            chk_valid <= 1'b0;
            state     <= start_scan ? S_SCAN : S_DONE;
            case (req.command)
              CMD_CLEAR: begin
                rule_count <= '0;
              end
              CMD_ADD: begin
                if (fam_ok && prefix_ok && !table_full) begin
                  rule_count <= rule_count + CNT_W'(1);
                end
              end
              default: begin
              end
            endcase
          end
        end

        S_SCAN: begin
          chk_valid <= rd_en;
          if (rd_en) begin
            issue_idx <= issue_idx + CNT_W'(1);
          end
          if (chk_valid && match) begin
            res.trusted <= 1'b1;
            if (use_fwd) begin
              res.used_forwarded   <= 1'b1;
              res.out_family       <= cur.fwd_is_v6 ? FAM_V6 : FAM_V4;
              res.out_address_high <= fwd_high;
              res.out_address_low  <= fwd_low;
            end
            state <= S_DONE;
          end else if (chk_valid && (issue_idx == rule_count)) begin
            // last entry checked without a hit
            state <= S_DONE;
          end
        end

        S_DONE: begin
          if (load_rsp) begin
            rsp   <= res;
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
